[design/efhc_pkg.sv]
// Shared constants, codes and the job word type of the frame header classifier.
`default_nettype none
package efhc_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam int unsigned CFG_IDX_W       = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_VLAN    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NATIVE_VLAN = 1'b1;

    localparam logic [1:0] VERDICT_SHORT     = 2'd0;
    localparam logic [1:0] VERDICT_VLAN_DROP = 2'd1;
    localparam logic [1:0] VERDICT_ARP       = 2'd2;
    localparam logic [1:0] VERDICT_OTHER     = 2'd3;

    localparam logic [1:0] ENCAP_PLAIN = 2'd0;
    localparam logic [1:0] ENCAP_SNAP  = 2'd1;
    localparam logic [1:0] ENCAP_VLAN  = 2'd2;

    localparam logic [15:0] TYPE_VLAN      = 16'h8100;
    localparam logic [15:0] TYPE_ARP       = 16'h0806;
    localparam logic [15:0] LEN_LIMIT_8022 = 16'd1514;
    localparam logic [15:0] VLAN_REG_RESET = 16'hFFFF;
    localparam logic [11:0] VLAN_NONE_ID   = 12'hFFF;

    localparam logic [4:0] HDR_PLAIN = 5'd14;
    localparam logic [4:0] HDR_VLAN  = 5'd18;
    localparam logic [4:0] HDR_8022  = 5'd22;

    localparam logic [4:0] POS_FIRST        = 5'd0;
    localparam logic [4:0] POS_TYPE_HI      = 5'd12;
    localparam logic [4:0] POS_TYPE_LO      = 5'd13;
    localparam logic [4:0] POS_TCI_HI       = 5'd14;
    localparam logic [4:0] POS_TCI_LO       = 5'd15;
    localparam logic [4:0] POS_VLAN_TYPE_HI = 5'd16;
    localparam logic [4:0] POS_VLAN_TYPE_LO = 5'd17;
    localparam logic [4:0] POS_SNAP_TYPE_HI = 5'd20;
    localparam logic [4:0] POS_SNAP_TYPE_LO = 5'd21;
    localparam logic [4:0] POS_MAX          = 5'd31;

    typedef struct packed {
        logic        short_frame;
        logic [1:0]  encap;
        logic [15:0] ether_type;
        logic        vlan_tagged;
        logic [11:0] tag_vid;
        logic [4:0]  offset;
        logic [15:0] frame_length;
    } t_job;

endpackage
`default_nettype wire

[design/efhc_front.sv]
// Front end: byte parser that tracks header position and issues one job per frame.
`default_nettype none
module efhc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_first_byte,
    input  wire logic [15:0]   i_frame_length,
    output efhc_pkg::t_job     o_job,
    output logic               o_job_valid
);
    import efhc_pkg::*;

    logic [4:0]  r_pos, n_pos;
    logic [15:0] r_outer, n_outer;
    logic [15:0] r_tci, n_tci;
    logic [15:0] r_inner, n_inner;
    logic [15:0] r_len;
    logic        r_given;

    logic        proc;
    logic [4:0]  p;
    logic [15:0] len;
    logic [15:0] outer;
    logic [15:0] tci;
    logic [15:0] inner;
    logic        job_hit;
    t_job        job;

    assign proc  = i_accept && (i_first_byte || !r_given);
    assign p     = i_first_byte ? POS_FIRST : r_pos;
    assign len   = i_first_byte ? i_frame_length : r_len;
    assign outer = i_first_byte ? 16'd0 : r_outer;
    assign tci   = i_first_byte ? 16'd0 : r_tci;
    assign inner = i_first_byte ? 16'd0 : r_inner;
    assign n_pos = (p == POS_MAX) ? POS_MAX : p + 5'd1;

    always_comb begin
        n_outer          = outer;
        n_tci            = tci;
        n_inner          = inner;
        job_hit          = 1'b0;
        job.short_frame  = 1'b1;
        job.encap        = ENCAP_PLAIN;
        job.ether_type   = 16'd0;
        job.vlan_tagged  = 1'b0;
        job.tag_vid      = VLAN_NONE_ID;
        job.offset       = 5'd0;
        job.frame_length = len;
        if (p == POS_FIRST && len < 16'(HDR_PLAIN)) begin
            job_hit = 1'b1;
        end else if (p == POS_TYPE_HI || p == POS_TYPE_LO) begin
            n_outer = {outer[7:0], i_data_byte};
            if (p == POS_TYPE_LO) begin
                if (n_outer < LEN_LIMIT_8022) begin
                    job_hit = len < 16'(HDR_8022);
                end else if (n_outer == TYPE_VLAN) begin
                    job_hit = len < 16'(HDR_VLAN);
                end else begin
                    job_hit         = 1'b1;
                    job.short_frame = 1'b0;
                    job.encap       = ENCAP_PLAIN;
                    job.ether_type  = n_outer;
                    job.offset      = HDR_PLAIN;
                end
            end
        end else if (p == POS_TCI_HI || p == POS_TCI_LO) begin
            n_tci = {tci[7:0], i_data_byte};
        end else if ((p == POS_VLAN_TYPE_HI || p == POS_VLAN_TYPE_LO)
                     && outer == TYPE_VLAN) begin
            n_inner = {inner[7:0], i_data_byte};
            if (p == POS_VLAN_TYPE_LO) begin
                job_hit         = 1'b1;
                job.short_frame = 1'b0;
                job.encap       = ENCAP_VLAN;
                job.ether_type  = n_inner;
                job.vlan_tagged = 1'b1;
                job.tag_vid     = tci[11:0];
                job.offset      = HDR_VLAN;
            end
        end else if ((p == POS_SNAP_TYPE_HI || p == POS_SNAP_TYPE_LO)
                     && outer < LEN_LIMIT_8022) begin
            n_inner = {inner[7:0], i_data_byte};
            if (p == POS_SNAP_TYPE_LO) begin
                job_hit         = 1'b1;
                job.short_frame = 1'b0;
                job.encap       = ENCAP_SNAP;
                job.ether_type  = n_inner;
                job.offset      = HDR_8022;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_FIRST;
            r_outer <= 16'd0;
            r_tci   <= 16'd0;
            r_inner <= 16'd0;
            r_len   <= 16'd0;
            r_given <= 1'b1;
        end else if (proc) begin
            r_pos   <= n_pos;
            r_outer <= n_outer;
            r_tci   <= n_tci;
            r_inner <= n_inner;
            r_len   <= len;
            r_given <= job_hit;
        end
    end

    assign o_job       = job;
    assign o_job_valid = proc && job_hit;

    // Bytes after a verdict never issue another job for the same frame.
    a_no_job_when_given: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_given && !i_first_byte) |-> !o_job_valid)
        else $error("job issued after verdict");

    a_short_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_first_byte && i_frame_length < 16'(HDR_PLAIN))
        |-> (o_job_valid && o_job.short_frame))
        else $error("short frame not flagged on first byte");

    a_given_after_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid |=> r_given)
        else $error("verdict flag not set after job");

endmodule
`default_nettype wire

[design/efhc_queue.sv]
// Short job queue between the parser front end and the classify back end.
`default_nettype none
module efhc_queue #(
    parameter int unsigned DEPTH = efhc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  efhc_pkg::t_job      i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output efhc_pkg::t_job      o_job,
    output logic                o_valid
);
    import efhc_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count out of range");

    a_ptrs_match_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr == r_rd))
        else $error("queue pointers differ while empty");

endmodule
`default_nettype wire

[design/efhc_back.sv]
// Back end: VLAN filter, verdict and payload length, with the result register.
`default_nettype none
module efhc_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    input  wire logic [efhc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [15:0]                       i_cfg_data,
    input  efhc_pkg::t_job                         i_job,
    input  wire logic                              i_job_valid,
    output logic                                   o_job_pop,
    output logic                                   o_empty,
    input  wire logic                              i_pop,
    output logic [1:0]                             o_verdict,
    output logic [1:0]                             o_encapsulation,
    output logic [15:0]                            o_ether_type,
    output logic [11:0]                            o_vlan_tag_id,
    output logic [4:0]                             o_payload_offset,
    output logic [15:0]                            o_payload_length
);
    import efhc_pkg::*;

    logic [15:0] r_own_vlan, r_native_vlan;
    logic        r_valid;
    logic [1:0]  r_verdict, n_verdict;
    logic [1:0]  r_encap, n_encap;
    logic [15:0] r_etype, n_etype;
    logic [11:0] r_vid, n_vid;
    logic [4:0]  r_offset, n_offset;
    logic [15:0] r_plen, n_plen;
    logic [11:0] own;
    logic [11:0] vid0;
    logic [15:0] off16;

    assign own       = r_own_vlan[11:0];
    assign vid0      = i_job.vlan_tagged ? i_job.tag_vid : VLAN_NONE_ID;
    assign off16     = 16'(i_job.offset);
    assign o_job_pop = i_job_valid && (!r_valid || i_pop);
    assign o_empty   = !r_valid;

    always_comb begin
        n_encap  = i_job.encap;
        n_etype  = i_job.ether_type;
        n_offset = i_job.offset;
        n_vid    = vid0;
        n_plen   = (i_job.frame_length >= off16) ? i_job.frame_length - off16 : 16'd0;
        if (i_job.vlan_tagged && own == VLAN_NONE_ID) begin
            n_verdict = VERDICT_VLAN_DROP;
        end else begin
            n_verdict = (i_job.ether_type == TYPE_ARP) ? VERDICT_ARP : VERDICT_OTHER;
            if (own != VLAN_NONE_ID) begin
                if (vid0 == VLAN_NONE_ID) begin
                    n_vid = r_native_vlan[11:0];
                end
                if (n_vid != own) begin
                    n_verdict = VERDICT_VLAN_DROP;
                end
            end
        end
        if (i_job.short_frame) begin
            n_verdict = VERDICT_SHORT;
            n_encap   = ENCAP_PLAIN;
            n_etype   = 16'd0;
            n_vid     = VLAN_NONE_ID;
            n_offset  = 5'd0;
            n_plen    = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_vlan    <= VLAN_REG_RESET;
            r_native_vlan <= VLAN_REG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OWN_VLAN:    r_own_vlan    <= i_cfg_data;
                CFG_NATIVE_VLAN: r_native_vlan <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_job_pop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_verdict <= n_verdict;
            r_encap   <= n_encap;
            r_etype   <= n_etype;
            r_vid     <= n_vid;
            r_offset  <= n_offset;
            r_plen    <= n_plen;
        end
    end

    assign o_verdict        = r_verdict;
    assign o_encapsulation  = r_encap;
    assign o_ether_type     = r_etype;
    assign o_vlan_tag_id    = r_vid;
    assign o_payload_offset = r_offset;
    assign o_payload_length = r_plen;

    a_short_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_verdict == VERDICT_SHORT)
        |-> (r_vid == VLAN_NONE_ID && r_offset == 5'd0 && r_plen == 16'd0))
        else $error("short verdict with nonzero fields");

    a_arp_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_verdict == VERDICT_ARP) |-> (r_etype == TYPE_ARP))
        else $error("ARP verdict with other type");

    a_no_pop_into_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_pop) |-> !o_job_pop)
        else $error("result overwritten before taken");

endmodule
`default_nettype wire

[design/ethernet_frame_header_classifier_unit.sv]
// Top level of the Ethernet frame header classifier: parser, job queue, classify stage.
//
//  channel  | handshake                 | word
//  ---------+---------------------------+-----------------------------------------------
//  input    | push / full               | i_data_byte, i_first_byte, i_frame_length
//  result   | empty / pop               | o_verdict, o_encapsulation, o_ether_type,
//           |                           | o_vlan_tag_id, o_payload_offset, o_payload_length
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One byte a cycle is taken while full is low; the parser decides in the cycle a byte arrives.
// A job enters the queue at the edge that takes its deciding byte and moves on into the result
// register once that register is empty or being popped; empty falls when it arrives there.
// full rises only when QUEUE_DEPTH jobs wait because pop is held low.
// Synchronous active-low reset; config writes are taken every cycle.
`default_nettype none
module ethernet_frame_header_classifier_unit #(
    parameter int unsigned QUEUE_DEPTH = efhc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [7:0]                        i_data_byte,
    input  wire logic                              i_first_byte,
    input  wire logic [15:0]                       i_frame_length,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [1:0]                             o_verdict,
    output logic [1:0]                             o_encapsulation,
    output logic [15:0]                            o_ether_type,
    output logic [11:0]                            o_vlan_tag_id,
    output logic [4:0]                             o_payload_offset,
    output logic [15:0]                            o_payload_length,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [efhc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [15:0]                       i_cfg_data
);
    import efhc_pkg::*;

    t_job front_job, queue_job;
    logic front_job_valid;
    logic queue_full, queue_valid, queue_pop;
    logic accept;

    assign accept      = push && !queue_full;
    assign full        = queue_full;
    assign o_cfg_ready = 1'b1;

    efhc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_data_byte    (i_data_byte),
        .i_first_byte   (i_first_byte),
        .i_frame_length (i_frame_length),
        .o_job          (front_job),
        .o_job_valid    (front_job_valid)
    );

    efhc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_job_valid),
        .i_job   (front_job),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_job   (queue_job),
        .o_valid (queue_valid)
    );

    efhc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_job            (queue_job),
        .i_job_valid      (queue_valid),
        .o_job_pop        (queue_pop),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_verdict        (o_verdict),
        .o_encapsulation  (o_encapsulation),
        .o_ether_type     (o_ether_type),
        .o_vlan_tag_id    (o_vlan_tag_id),
        .o_payload_offset (o_payload_offset),
        .o_payload_length (o_payload_length)
    );

endmodule
`default_nettype wire
